// ----- rtl/dpb_pkg.sv -----
// Shared types, widths and constants for the depth pixel back-projection block.
// Used by every module in rtl/; depends on nothing else.
package dpb_pkg;

  // Frame geometry and fixed-point format.
  localparam int MAX_DIM   = 4096;
  localparam int DIM_W     = $clog2(MAX_DIM);
  localparam int FRAC_BITS = 16;
  localparam int INV_FRAC  = 24;
  localparam int Z_SHIFT   = INV_FRAC - FRAC_BITS;

  // Field widths.
  localparam int DEPTH_W  = 16;
  localparam int COLOR_W  = 8;
  localparam int GEOM_W   = 13;
  localparam int COEF_W   = 24;
  localparam int COORD_W  = 24;
  localparam int Z_W      = 23;

  // Derived arithmetic widths.
  localparam int CMP_W   = ((DIM_W > GEOM_W) ? DIM_W : GEOM_W) + 1;
  localparam int D_W     = ((DIM_W + 1) > GEOM_W) ? (DIM_W + 1) : GEOM_W;
  localparam int ZF_W    = DEPTH_W + COEF_W;
  localparam int PROD_W  = D_W + Z_W;
  localparam int LO_W    = (PROD_W + 1) / 2;
  localparam int HI_W    = PROD_W - LO_W;
  localparam int PLO_W   = LO_W + COEF_W;
  localparam int PHI_W   = HI_W + COEF_W;
  localparam int SUM_W   = PROD_W + COEF_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X_TWICE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y_TWICE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_TWO_FOCAL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_TO_METERS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DEPTH_RAW   = 3'd6;

  localparam logic [GEOM_W-1:0]  RST_IMAGE_WIDTH     = 13'd640;
  localparam logic [GEOM_W-1:0]  RST_IMAGE_HEIGHT    = 13'd480;
  localparam logic [GEOM_W-1:0]  RST_CENTER_X_TWICE  = 13'd319;
  localparam logic [GEOM_W-1:0]  RST_CENTER_Y_TWICE  = 13'd239;
  localparam logic [COEF_W-1:0]  RST_INV_TWO_FOCAL   = 24'd27060;
  localparam logic [COEF_W-1:0]  RST_DEPTH_TO_METERS = 24'd16777;
  localparam logic [DEPTH_W-1:0] RST_MAX_DEPTH_RAW   = 16'd1200;

  // Queue sizes.
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);
  localparam int STAGES    = 4;
  localparam int INF_W     = $clog2(STAGES + 1);

  typedef struct packed {
    logic [GEOM_W-1:0]  image_width;
    logic [GEOM_W-1:0]  image_height;
    logic [GEOM_W-1:0]  center_x_twice;
    logic [GEOM_W-1:0]  center_y_twice;
    logic [COEF_W-1:0]  inv_two_focal;
    logic [COEF_W-1:0]  depth_to_meters;
    logic [DEPTH_W-1:0] max_depth_raw;
  } dpb_cfg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } dpb_color_t;

  typedef struct packed {
    logic [DIM_W-1:0]   col;
    logic [DIM_W-1:0]   row;
    logic [DEPTH_W-1:0] depth_raw;
    dpb_color_t         color;
  } dpb_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic [Z_W-1:0]     point_z;
    dpb_color_t         color;
  } dpb_result_t;

endpackage

// ----- rtl/dpb_queue.sv -----
// Short register queue of classified pixels between the front and the back end.
// Depends on dpb_pkg for the item type and queue depth.
module dpb_queue import dpb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr,
  input  dpb_item_t wdata,
  output logic      full,
  input  logic      rd,
  output dpb_item_t rdata,
  output logic      empty
);

  dpb_item_t            mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wptr;
  logic [Q_PTR_W-1:0]   rptr;
  logic [Q_CNT_W-1:0]   count;

  assign full  = (count == Q_CNT_W'(Q_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  // Storage is written only; it needs no reset.
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + 1'b1;
      end
      if (rd) begin
        rptr <= rptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= Q_CNT_W'(Q_DEPTH))
    else $error("queue fill level above its depth");
  a_count_step : assert property (@(posedge clk) disable iff (rst)
    (wr && !rd) |=> (count == $past(count) + 1'b1))
    else $error("queue fill level did not follow a lone write");
`endif

endmodule

// ----- rtl/dpb_front.sv -----
// Front end: accepts pixel requests, tracks column and row, drops empty or
// out-of-range depths and forwards the rest to the queue. Depends on dpb_pkg.
module dpb_front import dpb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  dpb_cfg_t           cfg,
  input  logic               push,
  input  logic [DEPTH_W-1:0] depth_raw,
  input  logic [COLOR_W-1:0] blue,
  input  logic [COLOR_W-1:0] green,
  input  logic [COLOR_W-1:0] red,
  output logic               full,
  input  logic               q_full,
  output logic               q_wr,
  output dpb_item_t          q_item
);

  logic [DIM_W-1:0] column_count;
  logic [DIM_W-1:0] row_count;
  logic [DIM_W-1:0] column_count_next;
  logic [DIM_W-1:0] row_count_next;
  logic             accept;
  logic             keep;
  logic             col_last;
  logic             row_last;

  assign full   = q_full;
  assign accept = push && !q_full;

  // A pixel is kept when its depth is non-zero and within the configured limit.
  assign keep = (depth_raw != '0) && (depth_raw <= cfg.max_depth_raw);
  assign q_wr = accept && keep;

  assign q_item.col         = column_count;
  assign q_item.row         = row_count;
  assign q_item.depth_raw   = depth_raw;
  assign q_item.color.blue  = blue;
  assign q_item.color.green = green;
  assign q_item.color.red   = red;

  // Wrap tests: the configured size, or the last position the counter can hold.
  assign col_last = ((CMP_W'(column_count) + CMP_W'(1)) >= CMP_W'(cfg.image_width)) ||
                    (column_count == DIM_W'(MAX_DIM - 1));
  assign row_last = ((CMP_W'(row_count) + CMP_W'(1)) >= CMP_W'(cfg.image_height)) ||
                    (row_count == DIM_W'(MAX_DIM - 1));

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (col_last) begin
      column_count_next = '0;
      row_count_next    = row_last ? '0 : row_count + 1'b1;
    end else begin
      column_count_next = column_count + 1'b1;
    end
  end

  // Every accepted pixel advances the position, dropped ones too.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

// ----- rtl/dpb_back.sv -----
// Back end: four-stage projection pipeline and the result queue behind it.
// Pulls items from dpb_queue only when the result queue has room; uses dpb_pkg.
module dpb_back import dpb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  dpb_cfg_t    cfg,
  input  logic        q_empty,
  output logic        q_rd,
  input  dpb_item_t   q_item,
  input  logic        pop,
  output logic        empty,
  output dpb_result_t result
);

  // Pipeline valid bits.
  logic v1, v2, v3, v4;

  // Stage 1: raw z product and offset magnitudes from the principal point.
  logic [ZF_W-1:0]  s1_zfull;
  logic [D_W-1:0]   s1_dx, s1_dy;
  logic             s1_negx, s1_negy;
  dpb_color_t       s1_color;

  // Stage 2: scaled and saturated z.
  logic [Z_W-1:0]   s2_z;
  logic [D_W-1:0]   s2_dx, s2_dy;
  logic             s2_negx, s2_negy;
  dpb_color_t       s2_color;

  // Stage 3: offset times z.
  logic [PROD_W-1:0] s3_px, s3_py;
  logic [Z_W-1:0]    s3_z;
  logic              s3_negx, s3_negy;
  dpb_color_t        s3_color;

  // Stage 4: partial products with the focal reciprocal.
  logic [PHI_W-1:0] s4_xhi, s4_yhi;
  logic [PLO_W-1:0] s4_xlo, s4_ylo;
  logic [Z_W-1:0]   s4_z;
  logic             s4_negx, s4_negy;
  dpb_color_t       s4_color;

  // Result queue.
  dpb_result_t          omem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] owptr;
  logic [OUT_PTR_W-1:0] orptr;
  logic [OUT_CNT_W-1:0] ocount;
  logic                 ord;
  dpb_result_t          res_next;

  logic [INF_W-1:0]       inflight;
  logic [OUT_CNT_W:0]     committed;
  logic [CMP_W-1:0]       twice_col, twice_row;
  logic                   negx_next, negy_next;
  logic [D_W-1:0]         dx_next, dy_next;
  logic [ZF_W-Z_SHIFT-1:0] z_shifted;

  // Signed offset as sign and magnitude: 2*pos - centre.
  function automatic logic [D_W-1:0] offset_mag(input logic [CMP_W-1:0] twice,
                                                 input logic [GEOM_W-1:0] centre,
                                                 input logic neg);
    logic [CMP_W-1:0] diff;
    begin
      diff = neg ? (CMP_W'(centre) - twice) : (twice - CMP_W'(centre));
      return D_W'(diff);
    end
  endfunction

  // Final coordinate: recombine the partial products, drop the Q0.24 fraction,
  // saturate and apply the sign.
  function automatic logic [COORD_W-1:0] finish(input logic [PHI_W-1:0] hi,
                                                input logic [PLO_W-1:0] lo,
                                                input logic neg);
    logic [SUM_W-1:0]   sum;
    logic [PROD_W-1:0]  mag;
    logic [PROD_W-1:0]  lim_neg;
    logic [PROD_W-1:0]  lim_pos;
    logic [COORD_W-1:0] sat;
    begin
      sum     = (SUM_W'(hi) << LO_W) + SUM_W'(lo);
      mag     = sum[SUM_W-1:INV_FRAC];
      lim_neg = PROD_W'(1) << (COORD_W - 1);
      lim_pos = lim_neg - PROD_W'(1);
      if (neg) begin
        sat = (mag > lim_neg) ? lim_neg[COORD_W-1:0] : mag[COORD_W-1:0];
        return COORD_W'(0) - sat;
      end else begin
        sat = (mag > lim_pos) ? lim_pos[COORD_W-1:0] : mag[COORD_W-1:0];
        return sat;
      end
    end
  endfunction

  // Issue only when every item in flight already has a place in the result queue.
  assign inflight  = INF_W'(v1) + INF_W'(v2) + INF_W'(v3) + INF_W'(v4);
  assign committed = (OUT_CNT_W + 1)'(ocount) + (OUT_CNT_W + 1)'(inflight);
  assign q_rd      = !q_empty && (committed < (OUT_CNT_W + 1)'(OUT_DEPTH));

  // Stage 1 inputs.
  assign twice_col = CMP_W'({q_item.col, 1'b0});
  assign twice_row = CMP_W'({q_item.row, 1'b0});
  assign negx_next = twice_col < CMP_W'(cfg.center_x_twice);
  assign negy_next = twice_row < CMP_W'(cfg.center_y_twice);
  assign dx_next   = offset_mag(twice_col, cfg.center_x_twice, negx_next);
  assign dy_next   = offset_mag(twice_row, cfg.center_y_twice, negy_next);

  // Stage 2 input: z scaled down to the output fraction.
  assign z_shifted = s1_zfull[ZF_W-1:Z_SHIFT];

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= q_rd;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    s1_zfull <= ZF_W'(q_item.depth_raw) * ZF_W'(cfg.depth_to_meters);
    s1_dx    <= dx_next;
    s1_dy    <= dy_next;
    s1_negx  <= negx_next;
    s1_negy  <= negy_next;
    s1_color <= q_item.color;

    if (z_shifted > (ZF_W - Z_SHIFT)'({Z_W{1'b1}})) begin
      s2_z <= {Z_W{1'b1}};
    end else begin
      s2_z <= z_shifted[Z_W-1:0];
    end
    s2_dx    <= s1_dx;
    s2_dy    <= s1_dy;
    s2_negx  <= s1_negx;
    s2_negy  <= s1_negy;
    s2_color <= s1_color;

    s3_px    <= PROD_W'(s2_dx) * PROD_W'(s2_z);
    s3_py    <= PROD_W'(s2_dy) * PROD_W'(s2_z);
    s3_z     <= s2_z;
    s3_negx  <= s2_negx;
    s3_negy  <= s2_negy;
    s3_color <= s2_color;

    s4_xhi   <= PHI_W'(s3_px[PROD_W-1:LO_W]) * PHI_W'(cfg.inv_two_focal);
    s4_xlo   <= PLO_W'(s3_px[LO_W-1:0]) * PLO_W'(cfg.inv_two_focal);
    s4_yhi   <= PHI_W'(s3_py[PROD_W-1:LO_W]) * PHI_W'(cfg.inv_two_focal);
    s4_ylo   <= PLO_W'(s3_py[LO_W-1:0]) * PLO_W'(cfg.inv_two_focal);
    s4_z     <= s3_z;
    s4_negx  <= s3_negx;
    s4_negy  <= s3_negy;
    s4_color <= s3_color;
  end

  // Result assembly.
  always_comb begin
    res_next.point_x = finish(s4_xhi, s4_xlo, s4_negx);
    res_next.point_y = finish(s4_yhi, s4_ylo, s4_negy);
    res_next.point_z = s4_z;
    res_next.color   = s4_color;
  end

  // Result queue.
  assign empty  = (ocount == '0);
  assign ord    = pop && !empty;
  assign result = omem[orptr];

  always_ff @(posedge clk) begin
    if (v4) begin
      omem[owptr] <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owptr  <= '0;
      orptr  <= '0;
      ocount <= '0;
    end else begin
      if (v4) begin
        owptr <= owptr + 1'b1;
      end
      if (ord) begin
        orptr <= orptr + 1'b1;
      end
      if (v4 && !ord) begin
        ocount <= ocount + 1'b1;
      end else if (ord && !v4) begin
        ocount <= ocount - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    v4 |-> (ocount < OUT_CNT_W'(OUT_DEPTH)))
    else $error("result written into a full result queue");
  a_credit : assert property (@(posedge clk) disable iff (rst)
    committed <= (OUT_CNT_W + 1)'(OUT_DEPTH))
    else $error("more results in flight than the result queue can hold");
`endif

endmodule

// ----- rtl/depth_pixel_backprojection.sv -----
// Top level of the depth pixel back-projection block: configuration registers,
// front end, pixel queue and back end. Depends on dpb_pkg, dpb_front,
// dpb_queue and dpb_back.
//
// Usage:
// - Pixels enter in raster order through push/full; a request is taken at a
//   clock edge with push high and full low. Each carries a raw depth and BGR.
// - Points leave through empty/pop; the oldest point is on the result ports
//   while empty is low and is taken at an edge with pop high and empty low.
// - A pixel with zero depth or a depth above max_depth_raw gives no point but
//   still advances the column and row counters.
// - A kept pixel passes through the pixel queue and the four pipeline stages
//   into the result queue before it shows on the result ports.
// - Throughput: one pixel per clock unless full; the back end pulls from the
//   pixel queue when the eight-entry result queue has room for all in flight.
// - When the receiver stalls, the result queue fills, the back end stops
//   pulling, the four-entry pixel queue fills and full rises.
// - Reset (rst, synchronous) empties both queues, clears the counters and
//   loads the default camera configuration. The user writes registers through
//   cfg_wen/cfg_index/cfg_data only while no pixel is in flight (unenforced).
module depth_pixel_backprojection import dpb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  push,
  output logic                  full,
  input  logic [DEPTH_W-1:0]    depth_raw,
  input  logic [COLOR_W-1:0]    blue,
  input  logic [COLOR_W-1:0]    green,
  input  logic [COLOR_W-1:0]    red,
  output logic                  empty,
  input  logic                  pop,
  output logic signed [COORD_W-1:0] point_x,
  output logic signed [COORD_W-1:0] point_y,
  output logic [Z_W-1:0]        point_z,
  output logic [COLOR_W-1:0]    out_blue,
  output logic [COLOR_W-1:0]    out_green,
  output logic [COLOR_W-1:0]    out_red
);

  dpb_cfg_t    cfg;
  logic        q_wr;
  logic        q_full;
  logic        q_rd;
  logic        q_empty;
  dpb_item_t   q_wdata;
  dpb_item_t   q_rdata;
  dpb_result_t result;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width     <= RST_IMAGE_WIDTH;
      cfg.image_height    <= RST_IMAGE_HEIGHT;
      cfg.center_x_twice  <= RST_CENTER_X_TWICE;
      cfg.center_y_twice  <= RST_CENTER_Y_TWICE;
      cfg.inv_two_focal   <= RST_INV_TWO_FOCAL;
      cfg.depth_to_meters <= RST_DEPTH_TO_METERS;
      cfg.max_depth_raw   <= RST_MAX_DEPTH_RAW;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:     cfg.image_width     <= cfg_data[GEOM_W-1:0];
        REG_IMAGE_HEIGHT:    cfg.image_height    <= cfg_data[GEOM_W-1:0];
        REG_CENTER_X_TWICE:  cfg.center_x_twice  <= cfg_data[GEOM_W-1:0];
        REG_CENTER_Y_TWICE:  cfg.center_y_twice  <= cfg_data[GEOM_W-1:0];
        REG_INV_TWO_FOCAL:   cfg.inv_two_focal   <= cfg_data[COEF_W-1:0];
        REG_DEPTH_TO_METERS: cfg.depth_to_meters <= cfg_data[COEF_W-1:0];
        REG_MAX_DEPTH_RAW:   cfg.max_depth_raw   <= cfg_data[DEPTH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Pixel intake and classification.
  dpb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .push      (push),
    .depth_raw (depth_raw),
    .blue      (blue),
    .green     (green),
    .red       (red),
    .full      (full),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_item    (q_wdata)
  );

  // Decoupling queue between front and back.
  dpb_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // Projection pipeline and result queue.
  dpb_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_rd    (q_rd),
    .q_item  (q_rdata),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

  // Result fields onto the ports.
  assign point_x   = $signed(result.point_x);
  assign point_y   = $signed(result.point_y);
  assign point_z   = result.point_z;
  assign out_blue  = result.color.blue;
  assign out_green = result.color.green;
  assign out_red   = result.color.red;

endmodule

// ----- verif/depth_pixel_backprojection_test.sv -----
// Self-checking test for depth_pixel_backprojection: pixel requests are fed through the queue
// interface and each returned point is compared with a local pinhole back-projection predictor.
// Depends on dpb_pkg and the block's RTL only.
module depth_pixel_backprojection_test;
  import dpb_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 10;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_PIXELS = 40;
  localparam int COUNTER_PIXELS = 16;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [Z_W-1:0] Z_MAX = 23'h7FFFFF;
  localparam logic [63:0] COORD_POS_MAX = 64'd8388607;
  localparam logic [63:0] COORD_NEG_MAX = 64'd8388608;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  logic [DEPTH_W-1:0] depth_raw = '0;
  logic [COLOR_W-1:0] blue = '0;
  logic [COLOR_W-1:0] green = '0;
  logic [COLOR_W-1:0] red = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic [Z_W-1:0] point_z;
  logic [COLOR_W-1:0] out_blue;
  logic [COLOR_W-1:0] out_green;
  logic [COLOR_W-1:0] out_red;

  // Predictor state: camera registers and pixel position of the next request.
  dpb_cfg_t cam_cfg;
  logic [DIM_W-1:0] pix_col;
  logic [DIM_W-1:0] pix_row;
  dpb_result_t pending_points[$];

  int mismatches = 0;
  int idle_cycles = 0;
  int pop_hold = 0;
  bit sender_idle = 1'b1;
  bit receiver_idle = 1'b1;

  depth_pixel_backprojection uut (
    .clk(clk), .rst(rst),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full),
    .depth_raw(depth_raw), .blue(blue), .green(green), .red(red),
    .empty(empty), .pop(pop),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .out_blue(out_blue), .out_green(out_green), .out_red(out_red)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One axis: signed offset from the principal point times z times the reciprocal,
  // truncated toward zero and saturated to the coordinate range.
  function automatic logic [COORD_W-1:0] project_axis(logic [DIM_W-1:0] pos,
                                                      logic [GEOM_W-1:0] centre2,
                                                      logic [Z_W-1:0] z);
    logic [GEOM_W:0] twice;
    logic [GEOM_W:0] offset;
    logic [63:0] mag;
    logic neg;
    twice = {1'b0, pos, 1'b0};
    neg = twice < {1'b0, centre2};
    offset = neg ? ({1'b0, centre2} - twice) : (twice - {1'b0, centre2});
    mag = (64'(offset) * 64'(z) * 64'(cam_cfg.inv_two_focal)) >> INV_FRAC;
    if (neg) begin
      if (mag > COORD_NEG_MAX) mag = COORD_NEG_MAX;
      return 24'd0 - mag[COORD_W-1:0];
    end
    if (mag > COORD_POS_MAX) mag = COORD_POS_MAX;
    return mag[COORD_W-1:0];
  endfunction

  function automatic dpb_result_t backproject_pixel(logic [DEPTH_W-1:0] d, dpb_color_t colour,
                                                    logic [DIM_W-1:0] c, logic [DIM_W-1:0] rw);
    dpb_result_t pt;
    logic [63:0] z_full;
    logic [Z_W-1:0] z;
    z_full = (64'(d) * 64'(cam_cfg.depth_to_meters)) >> Z_SHIFT;
    z = (z_full > 64'(Z_MAX)) ? Z_MAX : z_full[Z_W-1:0];
    pt.point_x = project_axis(c, cam_cfg.center_x_twice, z);
    pt.point_y = project_axis(rw, cam_cfg.center_y_twice, z);
    pt.point_z = z;
    pt.color = colour;
    return pt;
  endfunction

  // Raster counters; a size of zero behaves as one and anything above MAX_DIM as MAX_DIM.
  function automatic void step_counters();
    if (int'(pix_col) + 1 >= int'(cam_cfg.image_width) || int'(pix_col) >= MAX_DIM - 1) begin
      pix_col = '0;
      if (int'(pix_row) + 1 >= int'(cam_cfg.image_height) || int'(pix_row) >= MAX_DIM - 1)
        pix_row = '0;
      else
        pix_row = pix_row + 1'b1;
    end else begin
      pix_col = pix_col + 1'b1;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Offer one pixel request and predict its point once it is taken.
  task automatic send_pixel(input logic [DEPTH_W-1:0] d, input logic [COLOR_W-1:0] b,
                            input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] r);
    int gap;
    logic [DIM_W-1:0] c;
    logic [DIM_W-1:0] rw;
    dpb_color_t colour;
    gap = pick_gap(sender_idle);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    depth_raw <= d;
    blue <= b;
    green <= g;
    red <= r;
    @(posedge clk);
    while (full) @(posedge clk);
    c = pix_col;
    rw = pix_row;
    step_counters();
    colour.blue = b;
    colour.green = g;
    colour.red = r;
    if (d != '0 && d <= cam_cfg.max_depth_raw)
      pending_points.insert(pending_points.size(), backproject_pixel(d, colour, c, rw));
  endtask

  // Stop sending, wait for every predicted point, then let any dropped pixels clear.
  task automatic drain_points();
    push <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH:     cam_cfg.image_width = data[GEOM_W-1:0];
      REG_IMAGE_HEIGHT:    cam_cfg.image_height = data[GEOM_W-1:0];
      REG_CENTER_X_TWICE:  cam_cfg.center_x_twice = data[GEOM_W-1:0];
      REG_CENTER_Y_TWICE:  cam_cfg.center_y_twice = data[GEOM_W-1:0];
      REG_INV_TWO_FOCAL:   cam_cfg.inv_two_focal = data[COEF_W-1:0];
      REG_DEPTH_TO_METERS: cam_cfg.depth_to_meters = data[COEF_W-1:0];
      REG_MAX_DEPTH_RAW:   cam_cfg.max_depth_raw = data[DEPTH_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_camera(input int w, input int h, input int cx2, input int cy2,
                                input int inv, input int d2m, input int max_d);
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_CENTER_X_TWICE, CFG_DATA_W'(cx2));
    write_reg(REG_CENTER_Y_TWICE, CFG_DATA_W'(cy2));
    write_reg(REG_INV_TWO_FOCAL, CFG_DATA_W'(inv));
    write_reg(REG_DEPTH_TO_METERS, CFG_DATA_W'(d2m));
    write_reg(REG_MAX_DEPTH_RAW, CFG_DATA_W'(max_d));
  endtask

  // Mostly small frames so that wraps come often, sometimes large or arbitrary ones.
  function automatic int pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 16);
    if (r < 85) return $urandom_range(17, 700);
    return $urandom_range(0, 8191);
  endfunction

  function automatic int pick_centre(int dim);
    int hi;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 8191);
    hi = (2 * dim > 8191) ? 8191 : 2 * dim;
    return $urandom_range(0, hi);
  endfunction

  function automatic int pick_coef();
    if ($urandom_range(0, 1) == 0) return $urandom_range(1, 60000);
    return $urandom_range(1, 24'hFFFFFF);
  endfunction

  // Mostly measured depths within range; the rest missing or too far.
  function automatic logic [DEPTH_W-1:0] pick_depth();
    int r;
    int max_d;
    max_d = int'(cam_cfg.max_depth_raw);
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20 && max_d < 65535) return DEPTH_W'($urandom_range(max_d + 1, 65535));
    if (max_d == 0) return '0;
    return DEPTH_W'($urandom_range(1, max_d));
  endfunction

  task automatic send_random_pixel();
    send_pixel(pick_depth(), COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom));
  endtask

  // The default camera after reset: nearest, farthest, missing and too-far depths.
  task automatic test_reset_config();
    send_pixel(16'd1, 8'h00, 8'h00, 8'h00);
    send_pixel(16'd1200, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(16'd1201, 8'h12, 8'h34, 8'h56);
    send_pixel(16'd0, 8'hAA, 8'h55, 8'hAA);
    send_pixel(16'd600, 8'h55, 8'hAA, 8'h55);
    send_pixel(16'd65535, 8'h01, 8'h80, 8'hFE);
    drain_points();
  endtask

  // Saturation of x, y and z at both ends, tiny coefficients, and a zero depth limit.
  task automatic test_value_extremes();
    program_camera(2, 2, 8191, 0, 24'hFFFFFF, 24'hFFFFFF, 65535);
    repeat (4) send_pixel(16'd65535, 8'hFF, 8'h00, 8'hFF);
    send_pixel(16'd1, 8'h00, 8'hFF, 8'h00);
    drain_points();
    program_camera(2, 2, 0, 8191, 1, 1, 65535);
    send_pixel(16'd1, 8'h0F, 8'hF0, 8'h3C);
    send_pixel(16'd255, 8'hC3, 8'h5A, 8'hA5);
    send_pixel(16'd65535, 8'h7F, 8'h80, 8'h01);
    send_pixel(16'd65535, 8'h80, 8'h7F, 8'hFE);
    drain_points();
    write_reg(REG_INV_TWO_FOCAL, 24'hFFFFFF);
    send_pixel(16'd65535, 8'h11, 8'h22, 8'h33);
    send_pixel(16'd65535, 8'h44, 8'h55, 8'h66);
    drain_points();
    write_reg(REG_MAX_DEPTH_RAW, 24'd0);
    send_pixel(16'd1, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(16'd0, 8'h00, 8'h00, 8'h00);
    drain_points();
  endtask

  // Register data wider than the register is cut to width; an unknown index does nothing.
  task automatic test_register_masking();
    program_camera(24'hFFE003, 24'hFFFFFF, 24'hFFE005, 24'hFFFFFF, 24'd27060, 24'd16777,
                   24'hFF03E8);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    repeat (6) send_random_pixel();
    drain_points();
  endtask

  // A zero width acts as one, an oversized width does not wrap early, and a width cut
  // below the current column in mid-frame wraps at the next pixel.
  task automatic test_counter_limits();
    int i;
    program_camera(0, 24'hFFFFFF, $urandom_range(0, 8191), $urandom_range(0, 8191),
                   24'd27060, 24'd16777, 65535);
    for (i = 0; i < COUNTER_PIXELS; i++) send_random_pixel();
    drain_points();
    program_camera(8191, 3, $urandom_range(0, 8191), $urandom_range(0, 8191),
                   24'd27060, 24'd16777, 65535);
    for (i = 0; i < COUNTER_PIXELS; i++) send_random_pixel();
    drain_points();
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(2));
    for (i = 0; i < COUNTER_PIXELS; i++) send_random_pixel();
    drain_points();
  endtask

  // Random cameras between frames; one phase runs flat out, one pauses for the results.
  task automatic test_random_frames();
    int phase;
    int i;
    int w;
    int h;
    int max_d;
    int r;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      w = pick_dim();
      h = pick_dim();
      r = $urandom_range(0, 9);
      if (r < 4) max_d = $urandom_range(500, 2000);
      else if (r < 7) max_d = 65535;
      else max_d = $urandom_range(0, 65535);
      program_camera(w, h, pick_centre(w), pick_centre(h), pick_coef(), pick_coef(), max_d);
      sender_idle = (phase != 5);
      receiver_idle = (phase != 5);
      for (i = 0; i < PHASE_PIXELS; i++) begin
        if (phase == 3 && i == PHASE_PIXELS / 2) drain_points();
        send_random_pixel();
      end
      drain_points();
    end
    sender_idle = 1'b1;
    receiver_idle = 1'b1;
  endtask

  // Result side: check each taken point against the oldest prediction, then pace pop.
  always @(posedge clk) begin
    dpb_result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_points.size() == 0) begin
          report_mismatch("point returned with none predicted");
        end else begin
          want = pending_points.pop_front();
          if (point_x !== want.point_x)
            report_mismatch($sformatf("point_x got %0h want %0h", point_x, want.point_x));
          if (point_y !== want.point_y)
            report_mismatch($sformatf("point_y got %0h want %0h", point_y, want.point_y));
          if (point_z !== want.point_z)
            report_mismatch($sformatf("point_z got %0h want %0h", point_z, want.point_z));
          if (out_blue !== want.color.blue)
            report_mismatch($sformatf("out_blue got %0h want %0h", out_blue, want.color.blue));
          if (out_green !== want.color.green)
            report_mismatch($sformatf("out_green got %0h want %0h", out_green,
                                      want.color.green));
          if (out_red !== want.color.red)
            report_mismatch($sformatf("out_red got %0h want %0h", out_red, want.color.red));
        end
        pop_hold = pick_gap(receiver_idle);
      end
      if (pop_hold > 0) begin
        pop <= 1'b0;
        pop_hold--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any request taken on either side ends the run.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("depth_pixel_backprojection regression: fail");
        $finish;
      end
    end
  end

  initial begin
    cam_cfg.image_width = RST_IMAGE_WIDTH;
    cam_cfg.image_height = RST_IMAGE_HEIGHT;
    cam_cfg.center_x_twice = RST_CENTER_X_TWICE;
    cam_cfg.center_y_twice = RST_CENTER_Y_TWICE;
    cam_cfg.inv_two_focal = RST_INV_TWO_FOCAL;
    cam_cfg.depth_to_meters = RST_DEPTH_TO_METERS;
    cam_cfg.max_depth_raw = RST_MAX_DEPTH_RAW;
    pix_col = '0;
    pix_row = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_reset_config();
    test_value_extremes();
    test_register_masking();
    test_counter_limits();
    test_random_frames();
    drain_points();
    if (mismatches == 0)
      $display("depth_pixel_backprojection regression: pass");
    else
      $display("depth_pixel_backprojection regression: fail");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/dpb_pkg.sv
rtl/dpb_queue.sv
rtl/dpb_front.sv
rtl/dpb_back.sv
rtl/depth_pixel_backprojection.sv
verif/depth_pixel_backprojection_test.sv
